FILE: rtl/tcpd_pkg.sv
`timescale 1ns / 1ps

package tcpd_pkg;

    // word width of the data fields of the pixel and the result
    localparam int DW = 32;

    localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [1:0] {
        CLS_INVALID  = 2'd0,
        CLS_SURFACE  = 2'd1,
        CLS_DIHEDRAL = 2'd2
    } scatter_class_t;

    typedef struct packed {
        logic                 valid_req;
        logic [DW-1:0]        t11;
        logic [DW-1:0]        t22;
        logic [DW-1:0]        t33;
        logic signed [DW-1:0] t12_real;
        logic signed [DW-1:0] t12_imag;
    } pixel_t;

    typedef struct packed {
        scatter_class_t       scatter_class;
        logic signed [DW-1:0] alpha_ratio;
        logic signed [DW-1:0] beta_ratio;
        logic signed [DW-1:0] surface_coef;
        logic signed [DW-1:0] dihedral_coef;
        logic signed [DW-1:0] volume_coef;
        logic signed [DW-1:0] surface_power;
        logic signed [DW-1:0] dihedral_power;
        logic signed [DW-1:0] volume_power;
        logic                 divide_fault;
    } result_t;

    // saturate a one-bit-wider two's complement value into a word
    function automatic logic [DW-1:0] sat_w(input logic [DW:0] x);
        logic [DW-1:0] r;
        if (x[DW] != x[DW-1])
        begin
            r = x[DW] ? QMIN : QMAX;
        end
        else
        begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/tcpd_mul.sv
`timescale 1ns / 1ps

// unsigned multiplier, two registered partial products then a registered sum
module tcpd_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int LW = BW / 2;
    localparam int HW = BW - LW;

    logic [AW+LW-1:0] lo_reg;
    logic [AW+HW-1:0] hi_reg;
    logic [AW+BW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= a * b[LW-1:0];
            hi_reg <= a * b[BW-1:LW];
            p_reg  <= {hi_reg, {LW{1'b0}}} + (AW+BW)'(lo_reg);
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/tcpd_sqrt.sv
`timescale 1ns / 1ps

// floor square root, one result bit per stage
module tcpd_sqrt #(
    parameter int NB = 68
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NB-1:0]   radicand,
    output logic [NB/2-1:0] root
);

    localparam int H  = NB / 2;
    localparam int RW = H + 2;

    logic [NB-1:0] rad_reg  [H];
    logic [RW-1:0] rem_reg  [H];
    logic [H-1:0]  root_reg [H];

    genvar k;
    for (k = 0; k < H; k++)
    begin : g_step
        logic [NB-1:0] rad_in;
        logic [RW-1:0] rem_in;
        logic [H-1:0]  root_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh   = {rem_in[H-1:0], rad_in[NB-1-2*k -: 2]};
        assign trial    = {root_in, 2'b01};
        assign ge       = rem_sh >= trial;
        assign rem_next = ge ? rem_sh - trial : rem_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= {root_in[H-2:0], ge};
            end
        end
    end

    assign root = root_reg[H-1];

endmodule

FILE: rtl/three_component_polarimetric_decomp.sv
// Three-component polarimetric decomposition, one pixel per transfer. Each
// pixel carries T11, T22, T33 and complex T12 in Q(32-FRAC_BITS).FRAC_BITS and
// gives one result: the volume intensity (lesser of 4*T33 and the eigenvalue
// bound), the surface or dihedral class, the mechanism ratio, the three
// intensities and powers, all saturating, and a flag for a zero ratio divisor.
// A pixel with valid_req clear gives an all-zero result of class 0. The block
// takes one pixel per clock while pixel_stall is low and holds up to 83 in
// flight; a result's path runs through the 34-stage square root of the
// eigenvalue term and the 32-stage ratio divider, one bit per stage each.
// pixel_stall rises only while a finished result waits on result_stall.
`timescale 1ns / 1ps

module three_component_polarimetric_decomp
    import tcpd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pixel_valid,
    output logic    pixel_stall,
    input  pixel_t  pixel,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int W  = DW;
    localparam int H  = W + 2;     // square root steps
    localparam int NB = 2 * H;     // square root radicand width
    localparam int FD = H + 4;     // front payload line depth
    localparam logic [W-1:0] QONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef struct packed {
        logic         v;
        logic         vr;
        logic [W-1:0] t11;
        logic [W-1:0] t22;
        logic [W-1:0] t33;
    } front_t;

    typedef struct packed {
        logic         v;
        logic         vr;
        logic [W-1:0] t11;
        logic [W-1:0] t22;
        logic [W-1:0] mag;
        logic [W+1:0] fvc;
        logic [W+1:0] fv4;
    } fstage_t;

    typedef struct packed {
        logic         v;
        logic         vr;
        logic [W-1:0] t11;
        logic [W-1:0] t22;
        logic [W-1:0] mag;
        logic [W-2:0] fv;
    } gstage_t;

    // what travels with a pixel once the class is known
    typedef struct packed {
        logic         v;
        logic         vr;
        logic         surf;
        logic [W-1:0] p;     // intensity of the dominant mechanism
        logic [W-1:0] oth;   // reduced term of the other mechanism
        logic [W-2:0] fv;
    } tail_t;

    typedef struct packed {
        logic [W-1:0] r;
        logic [W-1:0] q;
        logic [W-1:0] dm;
        logic [W-1:0] num_lo;
        logic         ovf;
        logic         zero;
        logic         rneg;
    } div_t;

    typedef struct packed {
        tail_t tl;
        div_t  dv;
    } dstage_t;

    typedef struct packed {
        tail_t        tl;
        logic [W-1:0] y;
        logic [W-1:0] ratio;
        logic         fault;
    } jstage_t;

    typedef struct packed {
        tail_t        tl;
        logic [W-1:0] ratio;
        logic         fault;
        logic [W-1:0] pa;
        logic [W-2:0] sq2;
        logic [W-2:0] sq2p1;
    } lstage_t;

    typedef struct packed {
        tail_t        tl;
        logic [W-1:0] ratio;
        logic         fault;
        logic [W-1:0] m1;
        logic [W-1:0] m2;
    } nstage_t;

    // whole pipe moves unless the output holds an untaken result
    logic adv;
    assign adv         = !result_valid || !result_stall;
    assign pixel_stall = !adv;

    // input register
    logic   in_v_reg;
    pixel_t in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            in_reg   <= '0;
        end
        else if (adv)
        begin
            in_v_reg <= pixel_valid;
            in_reg   <= pixel;
        end
    end

    // magnitudes feeding the squares
    logic [W-1:0] abs_re;
    logic [W-1:0] abs_im;
    logic [W+1:0] a_diff;
    logic [W+1:0] a_neg;
    logic [W:0]   abs_a;

    assign abs_re = in_reg.t12_real[W-1] ? W'(-in_reg.t12_real) : in_reg.t12_real;
    assign abs_im = in_reg.t12_imag[W-1] ? W'(-in_reg.t12_imag) : in_reg.t12_imag;
    assign a_diff = {2'b00, in_reg.t11} - {1'b0, in_reg.t22, 1'b0};
    assign a_neg  = -a_diff;
    assign abs_a  = a_diff[W+1] ? a_neg[W:0] : a_diff[W:0];

    logic [2*W-1:0] re2;
    logic [2*W-1:0] im2;
    logic [2*W+1:0] a2;

    tcpd_mul #(.AW(W), .BW(W)) u_mul_re (
        .clk (clk), .en (adv), .a (abs_re), .b (abs_re), .p (re2)
    );

    tcpd_mul #(.AW(W), .BW(W)) u_mul_im (
        .clk (clk), .en (adv), .a (abs_im), .b (abs_im), .p (im2)
    );

    tcpd_mul #(.AW(W+1), .BW(W+1)) u_mul_a (
        .clk (clk), .en (adv), .a (abs_a), .b (abs_a), .p (a2)
    );

    // |T12|^2, then (T11 - 2*T22)^2 + 8*|T12|^2
    logic [2*W-1:0] sum_reg;
    logic [2*W+1:0] a2_reg;
    logic [2*W+2:0] tot_reg;
    logic [2*W-1:0] sumq_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg  <= re2 + im2;
            a2_reg   <= a2;
            tot_reg  <= {1'b0, a2_reg} + {sum_reg, 3'b000};
            sumq_reg <= sum_reg;
        end
    end

    logic [H-1:0] mag_root;
    logic [H-1:0] sq_root;

    tcpd_sqrt #(.NB(NB)) u_sqrt_mag (
        .clk      (clk),
        .en       (adv),
        .radicand ({4'b0000, sumq_reg}),
        .root     (mag_root)
    );

    tcpd_sqrt #(.NB(NB)) u_sqrt_eig (
        .clk      (clk),
        .en       (adv),
        .radicand ({1'b0, tot_reg}),
        .root     (sq_root)
    );

    // pixel terms ride alongside the squares and roots
    front_t front_reg [FD];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FD; i++)
            begin
                front_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            front_reg[0] <= '{v: in_v_reg, vr: in_reg.valid_req, t11: in_reg.t11,
                              t22: in_reg.t22, t33: in_reg.t33};
            for (int i = 1; i < FD; i++)
            begin
                front_reg[i] <= front_reg[i-1];
            end
        end
    end

    // eigenvalue bound |T11 + 2*T22 - root|
    front_t       fr;
    logic [W+2:0] es;
    logic [W+2:0] es_neg;
    fstage_t      f_next;
    fstage_t      f_reg;

    assign fr     = front_reg[FD-1];
    assign es     = {3'b000, fr.t11} + {2'b00, fr.t22, 1'b0} - {1'b0, sq_root};
    assign es_neg = -es;

    always_comb
    begin
        f_next.v   = fr.v;
        f_next.vr  = fr.vr;
        f_next.t11 = fr.t11;
        f_next.t22 = fr.t22;
        f_next.mag = mag_root[W-1:0];
        f_next.fvc = es[W+2] ? es_neg[W+1:0] : es[W+1:0];
        f_next.fv4 = {fr.t33, 2'b00};
    end

    // volume intensity, lesser of the two bounds, saturated
    logic [W+1:0] fv_min;
    gstage_t      g_next;
    gstage_t      g_reg;

    assign fv_min = (f_reg.fv4 < f_reg.fvc) ? f_reg.fv4 : f_reg.fvc;

    always_comb
    begin
        g_next.v   = f_reg.v;
        g_next.vr  = f_reg.vr;
        g_next.t11 = f_reg.t11;
        g_next.t22 = f_reg.t22;
        g_next.mag = f_reg.mag;
        g_next.fv  = (fv_min[W+1:W-1] != 3'b000) ? {(W-1){1'b1}} : fv_min[W-2:0];
    end

    // reduced diagonal terms and the dominance test
    logic [W:0]   d11;
    logic [W:0]   d22;
    logic [W-1:0] t11s;
    logic [W-1:0] t22s;
    logic [W:0]   dt;
    logic [W+3:0] dom;
    logic         surf;
    tail_t        h_next;
    tail_t        h_reg;
    logic [W-1:0] mag_h_reg;

    assign d11  = {1'b0, g_reg.t11} - {3'b000, g_reg.fv[W-2:1]};
    assign d22  = {1'b0, g_reg.t22} - {4'b0000, g_reg.fv[W-2:2]};
    assign t11s = sat_w(d11);
    assign t22s = sat_w(d22);
    assign dt   = {1'b0, g_reg.t11} - {1'b0, g_reg.t22};
    assign dom  = {dt[W], dt, 2'b00} - {5'b00000, g_reg.fv};
    assign surf = !dom[W+3] && (dom != '0);

    always_comb
    begin
        h_next.v    = g_reg.v;
        h_next.vr   = g_reg.vr;
        h_next.surf = surf;
        h_next.p    = surf ? t11s : t22s;
        h_next.oth  = surf ? t22s : t11s;
        h_next.fv   = g_reg.fv;
    end

    // divider setup: |divisor|, overflow check on the top bits, result sign
    logic [W-1:0] dm_i;
    logic [W-1:0] r0_i;
    dstage_t      ds_init;

    assign dm_i = h_reg.p[W-1] ? W'(-h_reg.p) : h_reg.p;
    assign r0_i = W'(mag_h_reg[W-1:W-FRAC_BITS]);

    always_comb
    begin
        ds_init.tl        = h_reg;
        ds_init.dv.r      = r0_i;
        ds_init.dv.q      = '0;
        ds_init.dv.dm     = dm_i;
        ds_init.dv.num_lo = {mag_h_reg[W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        ds_init.dv.ovf    = r0_i >= dm_i;
        ds_init.dv.zero   = (h_reg.p == '0);
        ds_init.dv.rneg   = h_reg.surf ? !h_reg.p[W-1] : h_reg.p[W-1];
    end

    // restoring divider, one quotient bit per stage
    dstage_t ds_reg [W+1];
    dstage_t ds_next [W];

    genvar k;
    for (k = 0; k < W; k++)
    begin : g_div
        logic [W:0] r_sh;
        logic [W:0] r_sub;
        logic       ge;

        assign r_sh  = {ds_reg[k].dv.r, ds_reg[k].dv.num_lo[W-1-k]};
        assign ge    = r_sh >= {1'b0, ds_reg[k].dv.dm};
        assign r_sub = r_sh - {1'b0, ds_reg[k].dv.dm};

        always_comb
        begin
            ds_next[k]      = ds_reg[k];
            ds_next[k].dv.r = ge ? r_sub[W-1:0] : r_sh[W-1:0];
            ds_next[k].dv.q = {ds_reg[k].dv.q[W-2:0], ge};
        end
    end

    // ratio: clamp to the signed range, zero divisor forces the end value
    dstage_t      dl;
    logic [W-1:0] lim_j;
    logic [W-1:0] y_j;
    logic         neg_j;
    jstage_t      j_next;
    jstage_t      j_reg;

    assign dl    = ds_reg[W];
    assign lim_j = dl.dv.rneg ? QMIN : QMAX;
    assign neg_j = dl.dv.zero ? dl.tl.surf : dl.dv.rneg;

    always_comb
    begin
        priority if (dl.dv.zero)
        begin
            y_j = dl.tl.surf ? QMIN : QMAX;
        end
        else if (dl.dv.ovf || (dl.dv.q > lim_j))
        begin
            y_j = lim_j;
        end
        else
        begin
            y_j = dl.dv.q;
        end
        j_next.tl    = dl.tl;
        j_next.y     = y_j;
        j_next.ratio = neg_j ? W'(-y_j) : y_j;
        j_next.fault = dl.dv.zero;
    end

    // ratio squared
    logic [2*W-1:0] yy;

    tcpd_mul #(.AW(W), .BW(W)) u_mul_y (
        .clk (clk), .en (adv), .a (j_reg.y), .b (j_reg.y), .p (yy)
    );

    jstage_t jd_reg [2];

    logic [2*W-1:0] yy_sh;
    logic [W-2:0]   sq2_l;
    logic [W-1:0]   sq2p1_w;
    lstage_t        l_next;
    lstage_t        l_reg;

    assign yy_sh   = yy >> FRAC_BITS;
    assign sq2_l   = (yy_sh > (2*W)'(QMAX)) ? QMAX[W-2:0] : yy_sh[W-2:0];
    assign sq2p1_w = {1'b0, sq2_l} + QONE;

    always_comb
    begin
        l_next.tl    = jd_reg[1].tl;
        l_next.ratio = jd_reg[1].ratio;
        l_next.fault = jd_reg[1].fault;
        l_next.pa    = jd_reg[1].tl.p[W-1] ? W'(-jd_reg[1].tl.p) : jd_reg[1].tl.p;
        l_next.sq2   = sq2_l;
        l_next.sq2p1 = sq2p1_w[W-1] ? QMAX[W-2:0] : sq2p1_w[W-2:0];
    end

    // dominant intensity times ratio^2 and times (1 + ratio^2)
    logic [2*W-2:0] pr1;
    logic [2*W-2:0] pr2;

    tcpd_mul #(.AW(W), .BW(W-1)) u_mul_m1 (
        .clk (clk), .en (adv), .a (l_reg.pa), .b (l_reg.sq2), .p (pr1)
    );

    tcpd_mul #(.AW(W), .BW(W-1)) u_mul_m2 (
        .clk (clk), .en (adv), .a (l_reg.pa), .b (l_reg.sq2p1), .p (pr2)
    );

    lstage_t ld_reg [2];

    logic           neg_n;
    logic [W-1:0]   lim_n;
    logic [2*W-2:0] sh1;
    logic [2*W-2:0] sh2;
    logic [W-1:0]   mag1;
    logic [W-1:0]   mag2;
    nstage_t        n_next;
    nstage_t        n_reg;

    assign neg_n = ld_reg[1].tl.p[W-1];
    assign lim_n = neg_n ? QMIN : QMAX;
    assign sh1   = pr1 >> FRAC_BITS;
    assign sh2   = pr2 >> FRAC_BITS;
    assign mag1  = (sh1 > (2*W-1)'(lim_n)) ? lim_n : sh1[W-1:0];
    assign mag2  = (sh2 > (2*W-1)'(lim_n)) ? lim_n : sh2[W-1:0];

    always_comb
    begin
        n_next.tl    = ld_reg[1].tl;
        n_next.ratio = ld_reg[1].ratio;
        n_next.fault = ld_reg[1].fault;
        n_next.m1    = neg_n ? W'(-mag1) : mag1;
        n_next.m2    = neg_n ? W'(-mag2) : mag2;
    end

    // other intensity and final assembly
    logic [W:0]   oth_diff;
    logic [W-1:0] oth_f;
    logic [W-1:0] fv_w;
    result_t      result_next;
    result_t      result_reg;
    logic         result_v_reg;

    assign oth_diff = {n_reg.tl.oth[W-1], n_reg.tl.oth} - {n_reg.m1[W-1], n_reg.m1};
    assign oth_f    = sat_w(oth_diff);
    assign fv_w     = {1'b0, n_reg.tl.fv};

    always_comb
    begin
        result_next = '0;
        if (n_reg.tl.vr)
        begin
            result_next.volume_coef  = fv_w;
            result_next.volume_power = fv_w;
            result_next.divide_fault = n_reg.fault;
            if (n_reg.tl.surf)
            begin
                result_next.scatter_class  = CLS_SURFACE;
                result_next.beta_ratio     = n_reg.ratio;
                result_next.surface_coef   = n_reg.tl.p;
                result_next.dihedral_coef  = oth_f;
                result_next.surface_power  = n_reg.m2;
                result_next.dihedral_power = oth_f;
            end
            else
            begin
                result_next.scatter_class  = CLS_DIHEDRAL;
                result_next.alpha_ratio    = n_reg.ratio;
                result_next.dihedral_coef  = n_reg.tl.p;
                result_next.surface_coef   = oth_f;
                result_next.dihedral_power = n_reg.m2;
                result_next.surface_power  = oth_f;
            end
        end
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg     <= '0;
            g_reg     <= '0;
            h_reg     <= '0;
            mag_h_reg <= '0;
            for (int i = 0; i <= W; i++)
            begin
                ds_reg[i] <= '0;
            end
            j_reg        <= '0;
            jd_reg[0]    <= '0;
            jd_reg[1]    <= '0;
            l_reg        <= '0;
            ld_reg[0]    <= '0;
            ld_reg[1]    <= '0;
            n_reg        <= '0;
            result_reg   <= '0;
            result_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_reg     <= f_next;
            g_reg     <= g_next;
            h_reg     <= h_next;
            mag_h_reg <= g_reg.mag;
            ds_reg[0] <= ds_init;
            for (int i = 0; i < W; i++)
            begin
                ds_reg[i+1] <= ds_next[i];
            end
            j_reg        <= j_next;
            jd_reg[0]    <= j_reg;
            jd_reg[1]    <= jd_reg[0];
            l_reg        <= l_next;
            ld_reg[0]    <= l_reg;
            ld_reg[1]    <= ld_reg[0];
            n_reg        <= n_next;
            result_reg   <= result_next;
            result_v_reg <= n_reg.tl.v;
        end
    end

    assign result_valid = result_v_reg;
    assign result       = result_reg;

    // an invalid pixel leaves nothing behind
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.scatter_class == CLS_INVALID) |->
            (result.alpha_ratio == '0 && result.beta_ratio == '0 &&
             result.surface_coef == '0 && result.volume_coef == '0 &&
             result.dihedral_power == '0 && !result.divide_fault))
        else $error("invalid pixel gave a nonzero result");

    // a zero divisor pins the ratio of the dominant mechanism
    a_fault_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.divide_fault) |->
            ((result.scatter_class == CLS_SURFACE && result.beta_ratio == QMIN) ||
             (result.scatter_class == CLS_DIHEDRAL && result.alpha_ratio == QMAX)))
        else $error("divide fault without a saturated ratio");

    // the pipe only holds back when a finished result is not taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (result_valid && result_stall))
        else $error("input stalled without output back pressure");

    // surface class keeps alpha zero and Pv equal to fv
    a_surface_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.scatter_class == CLS_SURFACE) |->
            (result.alpha_ratio == '0 && result.volume_power == result.volume_coef))
        else $error("surface result fields inconsistent");

endmodule
